FILE: hdl/ptps_pkg.sv
// Package for the process table priority scheduler.
// Holds request mode codes, task state codes, sequencer state codes and the cell control struct.
// No dependencies.
`default_nettype none
package ptps_pkg;

  typedef enum logic [3:0] {
    MODE_CREATE    = 4'd0,
    MODE_TERMINATE = 4'd1,
    MODE_ADD_THR   = 4'd2,
    MODE_SCHEDULE  = 4'd3,
    MODE_WAIT      = 4'd4,
    MODE_SET_PRIO  = 4'd5,
    MODE_GET_PRIO  = 4'd6,
    MODE_BLOCK     = 4'd7,
    MODE_UNBLOCK   = 4'd8,
    MODE_ADD_TICKS = 4'd9,
    MODE_GET_STATE = 4'd10
  } mode_t;

  localparam logic [2:0] ST_RUN     = 3'd1;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_ZOMBIE  = 3'd4;
  localparam logic [2:0] ST_CREATED = 3'd6;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WORK,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic        hit;
    logic [3:0]  mode;
    logic [7:0]  prio;
    logic [31:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/ptps_cell.sv
// One task slot of the table: state, priority, exit code, threads and ticks.
// Also one registered stage of the scheduling chain that carries the best candidate.
// Depends on ptps_pkg.
`default_nettype none
module ptps_cell #(
  parameter int THR_W = 5,
  parameter int ID_W  = 13
) (
  input  wire                  clk,
  input  wire ptps_pkg::cell_cmd_t cmd,
  input  wire                  pick_wr,
  input  wire [ID_W-1:0]       my_id,
  input  wire                  live,
  input  wire [THR_W-1:0]      max_thr,
  // Candidate from the previous cell.
  input  wire [7:0]            best_in,
  input  wire [ID_W-1:0]       pick_in,
  output logic [7:0]           best_out,
  output logic [ID_W-1:0]      pick_out,
  // Read side for the selected slot.
  output logic [2:0]           state_o,
  output logic [7:0]           prio_o,
  output logic [31:0]          exit_o,
  output logic [THR_W-1:0]     thr_o,
  output logic                 thr_ok_o
);
  import ptps_pkg::*;

  logic [2:0]       state_r;
  logic [7:0]       prio_r;
  logic [31:0]      exit_r;
  logic [THR_W-1:0] thr_r;
  logic [31:0]      ticks_r;
  logic             cand;
  logic [7:0]       best_r;
  logic [7:0]       best_nxt;
  logic [ID_W-1:0]  pick_r;
  logic [ID_W-1:0]  pick_nxt;

  // Chain link: take over if this slot beats the best so far.
  always_comb begin
    cand = live && (state_r == ST_READY || state_r == ST_CREATED) && (prio_r > best_in);
    best_nxt = cand ? prio_r : best_in;
    pick_nxt = cand ? my_id : pick_in;
  end

  // The candidate moves one cell along the chain in every cycle.
  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    pick_r <= pick_nxt;
  end

  assign best_out = best_r;
  assign pick_out = pick_r;

  assign state_o  = state_r;
  assign prio_o   = prio_r;
  assign exit_o   = exit_r;
  assign thr_o    = thr_r;
  assign thr_ok_o = thr_r < max_thr;

  // Slot update for the addressed request and for the slot picked by a schedule.
  always_ff @(posedge clk) begin
    if (pick_wr) begin
      state_r <= ST_RUN;
    end
    if (cmd.hit) begin
      case (cmd.mode)
        MODE_CREATE: begin
          state_r <= ST_CREATED;
          prio_r  <= cmd.prio;
          exit_r  <= '0;
          thr_r   <= '0;
          ticks_r <= '0;
        end
        MODE_TERMINATE: begin
          state_r <= ST_ZOMBIE;
          exit_r  <= cmd.value;
        end
        MODE_ADD_THR:   if (thr_ok_o) thr_r <= thr_r + 1'b1;
        MODE_SET_PRIO:  prio_r <= cmd.prio;
        MODE_BLOCK:     state_r <= ST_BLOCKED;
        MODE_UNBLOCK:   state_r <= ST_READY;
        MODE_ADD_TICKS: ticks_r <= ticks_r + cmd.value;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/process_table_priority_scheduler.sv
// Process table priority scheduler, top level. Depends on ptps_pkg, ptps_cell.
// A lookup request passes from the input beat through the work state to the output
// beat; a schedule adds the scan state, as the cell chain moves the best candidate
// one slot per cycle. One request is in flight at a time; the next beat is taken
// the cycle after the result leaves. Synchronous active-low reset clears the task
// count, running id and control; slot contents are defined only once a slot is
// created.
`default_nettype none
module process_table_priority_scheduler #(
  parameter int TABLE_SIZE  = 64,
  parameter int MAX_THREADS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  in_mode,
  input  wire  [12:0] in_task_id,
  input  wire  [7:0]  in_prio_in,
  input  wire  [31:0] in_value_in,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_ok,
  output logic [12:0] out_id_out,
  output logic [31:0] out_value_out
);
  import ptps_pkg::*;

  localparam int SW    = $clog2(TABLE_SIZE);
  localparam int CW    = $clog2(TABLE_SIZE + 1);
  localparam int THR_W = $clog2(MAX_THREADS + 1);
  localparam int ID_W  = 13;

  fsm_t            st_r, st_nxt;
  logic [CW-1:0]   count_r;
  logic [ID_W-1:0] running_r;
  logic [3:0]      mode_r;
  logic [ID_W-1:0] id_r;
  logic [7:0]      prio_r;
  logic [31:0]     val_r;
  logic            found_r;
  logic [SW-1:0]   slot_r;
  logic [SW-1:0]   scan_cnt_r;
  logic            ok_r;
  logic [ID_W-1:0] ido_r;
  logic [31:0]     vo_r;
  logic            ok_nxt;
  logic [ID_W-1:0] ido_nxt;
  logic [31:0]     vo_nxt;

  logic [7:0]       best_c [TABLE_SIZE+1];
  logic [ID_W-1:0]  pick_c [TABLE_SIZE+1];
  logic [2:0]       c_state [TABLE_SIZE];
  logic [7:0]       c_prio [TABLE_SIZE];
  logic [31:0]      c_exit [TABLE_SIZE];
  logic [THR_W-1:0] c_thr [TABLE_SIZE];
  logic             c_throk [TABLE_SIZE];
  logic             full;
  logic             do_work;
  logic             scan_last;
  logic [ID_W-1:0]  pick_end;

  assign full      = count_r == CW'(TABLE_SIZE);
  assign in_stall  = st_r != FSM_IDLE;
  assign out_valid = st_r == FSM_DONE;
  assign out_ok        = ok_r;
  assign out_id_out    = ido_r;
  assign out_value_out = vo_r;
  assign do_work   = st_r == FSM_WORK;
  // The last cell holds the full scan once the candidate has passed every slot.
  assign scan_last = st_r == FSM_SCAN && scan_cnt_r == SW'(TABLE_SIZE - 1);
  assign pick_end  = pick_c[TABLE_SIZE];

  assign best_c[0] = '0;
  assign pick_c[0] = '0;

  // Row of cells, one per slot, chained by best candidate.
  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
    cell_cmd_t cmd;
    logic      sel;
    assign sel = (mode_r == MODE_CREATE) ? (!full && count_r == CW'(g))
                                         : (found_r && slot_r == SW'(g));
    assign cmd.hit   = do_work && sel && mode_r != MODE_SCHEDULE;
    assign cmd.mode  = mode_r;
    assign cmd.prio  = prio_r;
    assign cmd.value = val_r;
    ptps_cell #(.THR_W(THR_W), .ID_W(ID_W)) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pick_wr  (scan_last && pick_end == ID_W'(g + 1)),
      .my_id    (ID_W'(g + 1)),
      .live     (CW'(g) < count_r),
      .max_thr  (THR_W'(MAX_THREADS)),
      .best_in  (best_c[g]),
      .pick_in  (pick_c[g]),
      .best_out (best_c[g+1]),
      .pick_out (pick_c[g+1]),
      .state_o  (c_state[g]),
      .prio_o   (c_prio[g]),
      .exit_o   (c_exit[g]),
      .thr_o    (c_thr[g]),
      .thr_ok_o (c_throk[g])
    );
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FSM_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FSM_IDLE: if (in_valid) st_nxt = FSM_WORK;
      FSM_WORK: st_nxt = (mode_r == MODE_SCHEDULE) ? FSM_SCAN : FSM_DONE;
      FSM_SCAN: if (scan_last) st_nxt = FSM_DONE;
      FSM_DONE: if (!out_stall) st_nxt = FSM_IDLE;
      default:  st_nxt = FSM_IDLE;
    endcase
  end

  // Result of a lookup request, from the selected slot or, for create, the task count.
  always_comb begin
    ok_nxt  = 1'b0;
    ido_nxt = '0;
    vo_nxt  = '0;
    case (mode_r)
      MODE_CREATE: if (!full) begin
        ok_nxt  = 1'b1;
        ido_nxt = ID_W'(count_r) + 1'b1;
      end
      MODE_TERMINATE, MODE_SET_PRIO, MODE_BLOCK, MODE_UNBLOCK, MODE_ADD_TICKS:
        ok_nxt = found_r;
      MODE_ADD_THR: if (found_r && c_throk[slot_r]) begin
        ok_nxt = 1'b1;
        vo_nxt = 32'(c_thr[slot_r]);
      end
      MODE_WAIT: if (found_r && c_state[slot_r] == ST_ZOMBIE) begin
        ok_nxt  = 1'b1;
        ido_nxt = id_r;
        vo_nxt  = c_exit[slot_r];
      end
      MODE_GET_PRIO: if (found_r) begin
        ok_nxt = 1'b1;
        vo_nxt = 32'(c_prio[slot_r]);
      end
      MODE_GET_STATE: if (found_r) begin
        ok_nxt = 1'b1;
        vo_nxt = 32'(c_state[slot_r]);
      end
      default: ;
    endcase
  end

  // Request capture, count, running id, scan counter and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      running_r <= '0;
    end else begin
      if (do_work && mode_r == MODE_CREATE && !full) count_r <= count_r + 1'b1;
      if (scan_last && pick_end != '0) running_r <= pick_end;
    end
    if (st_r == FSM_IDLE && in_valid) begin
      mode_r  <= in_mode;
      id_r    <= in_task_id;
      prio_r  <= in_prio_in;
      val_r   <= in_value_in;
      found_r <= in_task_id != '0 && 32'(in_task_id) <= 32'(count_r);
      slot_r  <= SW'(in_task_id - 1'b1);
    end
    if (do_work) begin
      scan_cnt_r <= '0;
      ok_r       <= ok_nxt;
      ido_r      <= ido_nxt;
      vo_r       <= vo_nxt;
    end
    if (st_r == FSM_SCAN) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
    if (scan_last) begin
      ok_r  <= pick_end != '0;
      ido_r <= pick_end;
      vo_r  <= '0;
    end
  end

  // Checks.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_SIZE) else $error("task count beyond table");
  a_run_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(running_r) <= 32'(count_r)) else $error("running id not created");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
endmodule
`default_nettype wire
